// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/rsx_pkg.sv -----
package rsx_pkg;

  // Default data memory depth and the width the branch target wraps to
  localparam int MEM_WORDS_DEF = 256;
  localparam int PC_BITS = 16;
  localparam logic [15:0] TARGET_MASK =
    (PC_BITS >= 16) ? 16'hFFFF : 16'((1 << PC_BITS) - 1);

  // Byte address shifted right by two
  localparam int WORD_ADDR_BITS = 30;

  // Register file
  localparam int REG_COUNT = 32;
  localparam int REG_AW = 5;

  // Command codes
  localparam logic [2:0] CMD_EXEC   = 3'd0;
  localparam logic [2:0] CMD_LD_REG = 3'd1;
  localparam logic [2:0] CMD_LD_MEM = 3'd2;
  localparam logic [2:0] CMD_RD_REG = 3'd3;
  localparam logic [2:0] CMD_RD_MEM = 3'd4;

  // Opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // R-type function codes
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_SLT = 6'd42;

  // Decoded and executed beat, handed from the execute logic to the control
  typedef struct packed {
    logic                      unk;
    logic                      rf_we;
    logic [REG_AW-1:0]         rf_dst;
    logic [31:0]               res;
    logic                      taken;
    logic [15:0]               target;
    logic                      addr_op;
    logic                      mem_rd;
    logic                      mem_wr;
    logic                      rd_reg;
    logic [WORD_ADDR_BITS-1:0] word_addr;
  } exec_t;

endpackage

// ----- src/risc_subset_execute_unit_top.sv -----
// Execute unit for a small load/store instruction subset.
// Input channel (in_valid / in_stall): one beat carries cmd and its operands;
// cmd selects execute, load register, load memory word, read register or
// read memory. A beat is taken when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall): one result beat per input beat, in
// order, held in an output register until taken.
// One beat is in flight at a time. ALU, branch, register load, register read
// and unsupported beats go from execute to done, which loads the output
// register. Stores and memory writes pass the word-index reduction and write
// the memory as they leave it; loads and memory reads also pass the memory
// read state. A power-of-two MEM_WORDS takes the low address bits as the word
// index; any other depth adds the registered steps of a reciprocal reduction.
// The registered register file read and the single-port data memory set this
// sequence. The next beat can be accepted the cycle after the result enters
// the output register. Reset (rst, synchronous) empties the register file
// through valid bits at once and zeroes the data memory in a sweep; in_stall
// stays high until the sweep ends. While out_stall holds a result, the unit
// still takes a new beat and works on it up to its result, then waits.
module risc_subset_execute_unit_top
  import rsx_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic [31:0]        instruction_word,
  input  logic [15:0]        pc,
  input  logic [4:0]         reg_index,
  input  logic [7:0]         mem_index,
  input  logic signed [31:0] load_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               branch_taken,
  output logic [15:0]        branch_target,
  output logic               reg_write,
  output logic [4:0]         dest_reg,
  output logic signed [31:0] result_value,
  output logic               mem_write,
  output logic [7:0]         mem_word,
  output logic signed [31:0] read_data,
  output logic               unknown_op
);

  localparam int MEM_AW = $clog2(MEM_WORDS);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_MOD   = 6'b001000,
    S_MEM   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state;
  logic              accept;

  logic [2:0]        cmd_q;
  logic [31:0]       iw_q;
  logic [15:0]       pc_q;
  logic [REG_AW-1:0] ri_q;
  logic [7:0]        mi_q;
  logic [31:0]       lv_q;
  exec_t             ex_c;
  exec_t             ex_q;
  logic [MEM_AW-1:0] slot_q;
  logic [31:0]       rdata_q;

  logic              rf_we;
  logic [REG_AW-1:0] rf_wa;
  logic [31:0]       rf_wd;
  logic [REG_AW-1:0] rf_ra_a;
  logic [31:0]       rf_rd_a;
  logic [31:0]       rf_rd_b;

  logic              dm_clearing;
  logic              dm_re;
  logic              dm_we;
  logic [31:0]       dm_rdata;

  logic              wm_start;
  logic              wm_done;
  logic [MEM_AW-1:0] wm_rem;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Register file: operands read at accept, written at execute or after a load
  assign rf_ra_a = (cmd == CMD_RD_REG) ? reg_index : instruction_word[25:21];
  assign rf_we   = ((state == S_EXEC) && ex_c.rf_we && !ex_c.mem_rd) ||
                   ((state == S_MEM) && ex_q.rf_we);
  assign rf_wa   = (state == S_MEM) ? ex_q.rf_dst : ex_c.rf_dst;
  assign rf_wd   = (state == S_MEM) ? dm_rdata : ex_c.res;

  rsx_regfile u_regfile (
    .clk  (clk),
    .rst  (rst),
    .re   (accept),
    .ra_a (rf_ra_a),
    .ra_b (instruction_word[20:16]),
    .rd_a (rf_rd_a),
    .rd_b (rf_rd_b),
    .we   (rf_we),
    .wa   (rf_wa),
    .wd   (rf_wd)
  );

  rsx_alu u_alu (
    .cmd (cmd_q),
    .iw  (iw_q),
    .pc  (pc_q),
    .ri  (ri_q),
    .mi  (mi_q),
    .lv  (lv_q),
    .a   (rf_rd_a),
    .b   (rf_rd_b),
    .ex  (ex_c)
  );

  // Word index reduction for loads, stores and memory commands
  assign wm_start = (state == S_EXEC) && ex_c.addr_op;

  rsx_wmod #(
    .MEM_WORDS (MEM_WORDS)
  ) u_wmod (
    .clk   (clk),
    .rst   (rst),
    .start (wm_start),
    .value (ex_c.word_addr),
    .done  (wm_done),
    .rem   (wm_rem)
  );

  assign dm_we = (state == S_MOD) && wm_done && ex_q.mem_wr;
  assign dm_re = (state == S_MOD) && wm_done && ex_q.mem_rd;

  rsx_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk      (clk),
    .rst      (rst),
    .clearing (dm_clearing),
    .re       (dm_re),
    .we       (dm_we),
    .addr     (wm_rem),
    .wd       (ex_q.res),
    .rdata    (dm_rdata)
  );

  // Control sequence and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (!dm_clearing) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q <= cmd;
            iw_q  <= instruction_word;
            pc_q  <= pc;
            ri_q  <= reg_index;
            mi_q  <= mem_index;
            lv_q  <= load_value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          ex_q    <= ex_c;
          rdata_q <= ex_c.rd_reg ? rf_rd_a : 32'd0;
          slot_q  <= '0;
          state   <= ex_c.addr_op ? S_MOD : S_DONE;
        end
        S_MOD: begin
          if (wm_done) begin
            slot_q <= wm_rem;
            state  <= ex_q.mem_rd ? S_MEM : S_DONE;
          end
        end
        S_MEM: begin
          if (ex_q.rf_we) begin
            ex_q.res <= dm_rdata;
          end else begin
            rdata_q <= dm_rdata;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            branch_taken  <= ex_q.taken;
            branch_target <= ex_q.target;
            reg_write     <= ex_q.rf_we && (ex_q.rf_dst != '0);
            dest_reg      <= (ex_q.rf_we && (ex_q.rf_dst != '0)) ? ex_q.rf_dst : '0;
            result_value  <= ex_q.res;
            mem_write     <= ex_q.mem_wr;
            mem_word      <= ex_q.addr_op ? 8'(slot_q) : 8'd0;
            read_data     <= rdata_q;
            unknown_op    <= ex_q.unk;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/rsx_regfile.sv -----
module rsx_regfile
  import rsx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              re,
  input  logic [REG_AW-1:0] ra_a,
  input  logic [REG_AW-1:0] ra_b,
  output logic [31:0]       rd_a,
  output logic [31:0]       rd_b,
  input  logic              we,
  input  logic [REG_AW-1:0] wa,
  input  logic [31:0]       wd
);

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;

  // Write port; register zero is never written and so always reads zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we && (wa != '0)) begin
      valid[wa] <= 1'b1;
    end
    if (we && (wa != '0)) begin
      mem[wa] <= wd;
    end
  end

  // Two registered read ports; entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (re) begin
      rd_a <= valid[ra_a] ? mem[ra_a] : 32'd0;
      rd_b <= valid[ra_b] ? mem[ra_b] : 32'd0;
    end
  end

endmodule

// ----- src/rsx_dmem.sv -----
module rsx_dmem
  import rsx_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  output logic                         clearing,
  input  logic                         re,
  input  logic                         we,
  input  logic [$clog2(MEM_WORDS)-1:0] addr,
  input  logic [31:0]                  wd,
  output logic [31:0]                  rdata
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0]   mem [MEM_WORDS];
  logic [AW-1:0] clr_addr;

  // Zeroing sweep after reset, one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(MEM_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single port: sweep write, functional write, or registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 32'd0;
    end else if (we) begin
      mem[addr] <= wd;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- src/rsx_wmod.sv -----
module rsx_wmod
  import rsx_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [WORD_ADDR_BITS-1:0]    value,
  output logic                         done,
  output logic [$clog2(MEM_WORDS)-1:0] rem
);

  localparam int AW    = $clog2(MEM_WORDS);
  localparam bit POW2  = (MEM_WORDS & (MEM_WORDS - 1)) == 0;

  if (POW2) begin : g_mask
    // Power-of-two depth: the word index is the low address bits
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      if (start) begin
        rem <= value[AW-1:0];
      end
    end
  end else begin : g_recip
    localparam int KSH = WORD_ADDR_BITS + AW;
    localparam int RW  = WORD_ADDR_BITS + 1;
    localparam int PW  = WORD_ADDR_BITS + RW;
    localparam logic [63:0] RECIP64 =
      ((64'd1 << KSH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
    localparam logic [RW-1:0] RECIP   = RW'(RECIP64);
    localparam logic [AW:0]   DIVISOR = (AW+1)'(MEM_WORDS);

    logic [WORD_ADDR_BITS-1:0]  val_a;
    logic [WORD_ADDR_BITS-1:0]  val_b;
    logic [PW-1:0]              prod_q;
    logic [WORD_ADDR_BITS-1:0]  quo;
    logic [WORD_ADDR_BITS+AW:0] back;
    logic [WORD_ADDR_BITS-1:0]  diff;
    logic                       st_a;
    logic                       st_b;
    logic [AW-1:0]              rem_q;

    // Quotient by the rounded-up reciprocal of the depth, exact for 30-bit addresses
    assign quo  = WORD_ADDR_BITS'(prod_q >> KSH);
    assign back = {{(AW+1){1'b0}}, quo} * {{WORD_ADDR_BITS{1'b0}}, DIVISOR};
    assign diff = val_b - back[WORD_ADDR_BITS-1:0];

    // Three stages: capture, multiply, subtract
    always_ff @(posedge clk) begin
      if (rst) begin
        st_a <= 1'b0;
        st_b <= 1'b0;
        done <= 1'b0;
      end else begin
        st_a <= start;
        st_b <= st_a;
        done <= st_b;
      end
      if (start) begin
        val_a <= value;
      end
      if (st_a) begin
        val_b  <= val_a;
        prod_q <= {{RW{1'b0}}, val_a} * {{WORD_ADDR_BITS{1'b0}}, RECIP};
      end
      if (st_b) begin
        rem_q <= diff[AW-1:0];
      end
    end

    assign rem = rem_q;
  end

endmodule

// ----- src/rsx_alu.sv -----
module rsx_alu
  import rsx_pkg::*;
(
  input  logic [2:0]        cmd,
  input  logic [31:0]       iw,
  input  logic [15:0]       pc,
  input  logic [REG_AW-1:0] ri,
  input  logic [7:0]        mi,
  input  logic [31:0]       lv,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output exec_t             ex
);

  logic [5:0]        op;
  logic [5:0]        fn;
  logic [REG_AW-1:0] rt;
  logic [REG_AW-1:0] rd;
  logic [31:0]       imm;
  logic [31:0]       ea;
  logic [15:0]       tgt;

  assign op  = iw[31:26];
  assign rt  = iw[20:16];
  assign rd  = iw[15:11];
  assign fn  = iw[5:0];
  assign imm = {{16{iw[15]}}, iw[15:0]};
  assign ea  = a + imm;
  assign tgt = (pc + 16'd4 + {imm[13:0], 2'b00}) & TARGET_MASK;

  // Decode and execute one beat
  always_comb begin
    ex = '0;
    case (cmd)
      CMD_EXEC: begin
        case (op)
          OP_RTYPE: begin
            ex.rf_dst = rd;
            case (fn)
              FN_ADD: begin
                ex.res   = a + b;
                ex.rf_we = 1'b1;
              end
              FN_SUB: begin
                ex.res   = a - b;
                ex.rf_we = 1'b1;
              end
              FN_SLT: begin
                ex.res   = {31'd0, $signed(a) < $signed(b)};
                ex.rf_we = 1'b1;
              end
              default: begin
                ex.unk = 1'b1;
              end
            endcase
          end
          OP_ADDI: begin
            ex.res    = ea;
            ex.rf_we  = 1'b1;
            ex.rf_dst = rt;
          end
          OP_LW: begin
            ex.addr_op   = 1'b1;
            ex.mem_rd    = 1'b1;
            ex.rf_we     = 1'b1;
            ex.rf_dst    = rt;
            ex.word_addr = ea[31:2];
          end
          OP_SW: begin
            ex.addr_op   = 1'b1;
            ex.mem_wr    = 1'b1;
            ex.res       = b;
            ex.word_addr = ea[31:2];
          end
          OP_BEQ: begin
            ex.target = tgt;
            ex.taken  = (a == b);
          end
          OP_BNE: begin
            ex.target = tgt;
            ex.taken  = (a != b);
          end
          default: begin
            ex.unk = 1'b1;
          end
        endcase
      end
      CMD_LD_REG: begin
        ex.rf_we  = 1'b1;
        ex.rf_dst = ri;
        ex.res    = lv;
      end
      CMD_LD_MEM: begin
        ex.addr_op   = 1'b1;
        ex.mem_wr    = 1'b1;
        ex.res       = lv;
        ex.word_addr = WORD_ADDR_BITS'(mi);
      end
      CMD_RD_REG: begin
        ex.rd_reg = 1'b1;
      end
      CMD_RD_MEM: begin
        ex.addr_op   = 1'b1;
        ex.mem_rd    = 1'b1;
        ex.word_addr = WORD_ADDR_BITS'(mi);
      end
      default: begin
        ex.unk = 1'b1;
      end
    endcase
  end

endmodule

// ----- src/rsx_checker.sv -----
`include "assert_macros.svh"

module rsx_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               branch_taken,
  input logic [15:0]        branch_target,
  input logic               reg_write,
  input logic [4:0]         dest_reg,
  input logic signed [31:0] result_value,
  input logic               mem_write,
  input logic [7:0]         mem_word,
  input logic signed [31:0] read_data,
  input logic               unknown_op
);

  logic [96:0] out_bundle;
  logic        out_held;
  logic        fields_clear;

  // All result fields side by side
  assign out_bundle = {branch_taken, branch_target, reg_write, dest_reg, result_value,
                       mem_write, mem_word, read_data, unknown_op};
  assign out_held   = out_valid && out_stall;
  assign fields_clear = !reg_write && !mem_write && !branch_taken &&
                        (result_value == 32'sd0) && (read_data == 32'sd0) &&
                        (branch_target == 16'd0) && (mem_word == 8'd0);

  // One beat in flight: the unit stalls right after taking a beat
  `ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "beat taken while busy")

  // A held result stays put
  `ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_bundle), "held result changed")

  // Register zero is never reported as written
  `ASSERT_IMPL(a_no_reg0_write, out_valid && reg_write, dest_reg != 5'd0, "reg zero written")

  // An unsupported code leaves every other field clear; dest_reg is not checked here
  `ASSERT_IMPL(a_unknown_quiet, out_valid && unknown_op, fields_clear, "unknown code not quiet")

endmodule

bind risc_subset_execute_unit_top rsx_checker u_rsx_checker (.*);
